[rtl/id3t_pkg.sv]
// shared constants, encoding codes and the job record for the id3 text transcoder
package id3t_pkg;

   localparam int MAX_CAPACITY = 4096;
   localparam int CAP_W        = 13;
   localparam int CNT_W        = CAP_W + 1;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   localparam logic [7:0] ENC_LATIN1    = 8'd0;
   localparam logic [7:0] ENC_UTF16_BOM = 8'd1;
   localparam logic [7:0] ENC_UTF16BE   = 8'd2;
   localparam logic [7:0] ENC_UTF8      = 8'd3;

   localparam logic [7:0] BOM_HI = 8'hFE;
   localparam logic [7:0] BOM_LO = 8'hFF;

   // bytes of one input item to be sent, data[0] goes out first
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      len;
      logic            term;
   } job_type;

endpackage

[rtl/id3_text_to_utf8.sv]
// top level of the id3 text to utf-8 transcoder
// Input stream req_*: one raw byte of an id3 text string a beat. req_tuser[7:0]
// carries the encoding code (0 latin-1, 1 utf-16 with optional bom, 2 utf-16be,
// 3 utf-8, others utf-16le), read only on a beat with req_tuser[8] set, which
// starts a new string. req_tlast marks the final byte; a terminator follows it.
// Output stream rsp_*: one utf-8 byte a beat; the terminator has data zero and
// rsp_tlast high. csr_we/csr_wdata set the output capacity (clamped to 4096).
// The front decodes one item a cycle while the queue is not full into a job of
// up to three bytes plus an optional terminator and writes it into a four-entry
// queue. The back sends one byte a cycle from the queue into the output register
// unless rsp_tready stalls: one beat for ascii, two or three for wider characters,
// one more for a terminator. An accepted item passes through the queue, the back's
// job register and the output register. req_tready drops only while the queue is
// full. A stall on rsp_tready holds the output register; the queue fills behind it.
// Reset clears the queue and output, sets capacity 128 and latin-1 state.
module id3_text_to_utf8 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [id3t_pkg::CAP_W-1:0]  csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,  // raw_byte
   input  logic [8:0]                  req_tuser,  // text_encoding [7:0], first_byte [8]
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,  // out_byte
   output logic                        rsp_tlast
);

   logic              push;
   logic              full;
   logic              pop;
   logic              fvalid;
   id3t_pkg::job_type push_job;
   id3t_pkg::job_type pop_job;

   id3t_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .fifo_full  (full),
      .push       (push),
      .push_job   (push_job)
   );

   id3t_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .valid    (fvalid),
      .pop_job  (pop_job)
   );

   id3t_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_valid (fvalid),
      .fifo_job   (pop_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/id3t_front.sv]
// front: latches per-string state, decodes each byte and builds the job for the back end
module id3t_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [id3t_pkg::CAP_W-1:0]  csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,
   input  logic [8:0]                  req_tuser,
   input  logic                        req_tlast,
   input  logic                        fifo_full,
   output logic                        push,
   output id3t_pkg::job_type           push_job
);

   logic [id3t_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [7:0]                 enc_ff, enc_in;
   logic [id3t_pkg::CAP_W-1:0] count_ff, count_in;
   logic [7:0]                 held_ff, held_in;
   logic                       have_ff, have_in;
   logic                       big_ff, big_in;
   logic                       fp_ff, fp_in;
   logic                       stop_ff, stop_in;

   logic       accept;
   logic       first;
   logic       emit;
   logic [15:0] cp;
   logic       mark;
   logic [1:0] need;
   logic [2:0][7:0] bytes;
   logic       fits;
   id3t_pkg::job_type job;

   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && req_tready;
   assign first      = req_tuser[8];

   always_comb begin
      cap_in = cap_ff;
      if (csr_we) begin
         cap_in = (csr_wdata > id3t_pkg::CAP_W'(id3t_pkg::MAX_CAPACITY))
                  ? id3t_pkg::CAP_W'(id3t_pkg::MAX_CAPACITY) : csr_wdata;
      end
   end

   always_comb begin
      enc_in   = first ? req_tuser[7:0] : enc_ff;
      count_in = first ? '0 : count_ff;
      held_in  = held_ff;
      have_in  = first ? 1'b0 : have_ff;
      big_in   = first ? (req_tuser[7:0] == id3t_pkg::ENC_UTF16BE) : big_ff;
      fp_in    = first ? 1'b1 : fp_ff;
      stop_in  = first ? 1'b0 : stop_ff;
      emit     = 1'b0;
      cp       = {8'd0, req_tdata};
      mark     = 1'b0;
      job      = '0;

      if (!stop_in) begin
         if (enc_in == id3t_pkg::ENC_LATIN1 || enc_in == id3t_pkg::ENC_UTF8) begin
            if (req_tdata == 8'd0) begin
               stop_in = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end else if (!have_in) begin
            held_in = req_tdata;
            have_in = 1'b1;
         end else begin
            have_in = 1'b0;
            if (fp_in && enc_in == id3t_pkg::ENC_UTF16_BOM) begin
               if (held_ff == id3t_pkg::BOM_HI && req_tdata == id3t_pkg::BOM_LO) begin
                  big_in = 1'b1;
                  mark   = 1'b1;
               end else if (held_ff == id3t_pkg::BOM_LO && req_tdata == id3t_pkg::BOM_HI) begin
                  big_in = 1'b0;
                  mark   = 1'b1;
               end
            end
            fp_in = 1'b0;
            if (!mark) begin
               cp = big_in ? {held_ff, req_tdata} : {req_tdata, held_ff};
               if (cp == 16'd0) begin
                  stop_in = 1'b1;
               end else begin
                  emit = 1'b1;
               end
            end
         end
      end

      // utf-8 passthrough copies the byte as is; other code points become one to three utf-8 bytes
      if (enc_in == id3t_pkg::ENC_UTF8 || cp < 16'h0080) begin
         need  = 2'd1;
         bytes = {8'd0, 8'd0, cp[7:0]};
      end else if (cp < 16'h0800) begin
         need  = 2'd2;
         bytes = {8'd0, {2'b10, cp[5:0]}, {3'b110, cp[10:6]}};
      end else begin
         need  = 2'd3;
         bytes = {{2'b10, cp[5:0]}, {2'b10, cp[11:6]}, {4'b1110, cp[15:12]}};
      end

      fits = ({1'b0, count_in} + id3t_pkg::CNT_W'(need)) < {1'b0, cap_ff};
      if (emit && fits) begin
         job.data = bytes;
         job.len  = need;
         count_in = count_in + id3t_pkg::CAP_W'(need);
      end

      if (req_tlast) begin
         job.term = 1'b1;
         stop_in  = 1'b1;
         have_in  = 1'b0;
      end
   end

   assign push     = accept && (job.len != 2'd0 || job.term);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= id3t_pkg::CAP_RESET;
         enc_ff   <= id3t_pkg::ENC_LATIN1;
         count_ff <= '0;
         held_ff  <= '0;
         have_ff  <= 1'b0;
         big_ff   <= 1'b0;
         fp_ff    <= 1'b1;
         stop_ff  <= 1'b0;
      end else begin
         cap_ff <= cap_in;
         if (accept) begin
            enc_ff   <= enc_in;
            count_ff <= count_in;
            held_ff  <= held_in;
            have_ff  <= have_in;
            big_ff   <= big_in;
            fp_ff    <= fp_in;
            stop_ff  <= stop_in;
         end
      end
   end

endmodule

[rtl/id3t_fifo.sv]
// short job queue between the front and the back
module id3t_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  id3t_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output id3t_pkg::job_type pop_job
);

   id3t_pkg::job_type                 mem_ff [id3t_pkg::FIFO_DEPTH];
   logic [id3t_pkg::PTR_W-1:0]        wr_ff, wr_in;
   logic [id3t_pkg::PTR_W-1:0]        rd_ff, rd_in;
   logic [id3t_pkg::PTR_W:0]          cnt_ff, cnt_in;

   assign full    = (cnt_ff == (id3t_pkg::PTR_W+1)'(id3t_pkg::FIFO_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign pop_job = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/id3t_back.sv]
// back: walks each job one byte a beat into the output register
module id3t_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              fifo_valid,
   input  id3t_pkg::job_type fifo_job,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);

   id3t_pkg::job_type job_ff, job_in;
   logic              jv_ff, jv_in;
   logic [1:0]        pos_ff, pos_in;
   logic              ov_ff, ov_in;
   logic [7:0]        ob_ff, ob_in;
   logic              oe_ff, oe_in;

   logic       adv;
   logic       is_data;
   logic       last_beat;
   logic [2:0] total;
   logic [7:0] beat;

   assign total     = {1'b0, job_ff.len} + {2'b00, job_ff.term};
   assign is_data   = pos_ff < job_ff.len;
   assign last_beat = ({1'b0, pos_ff} + 3'd1) == total;
   assign adv       = jv_ff && (!ov_ff || rsp_tready);
   assign pop       = fifo_valid && (!jv_ff || (adv && last_beat));

   always_comb begin
      case (pos_ff)
         2'd0:    beat = job_ff.data[0];
         2'd1:    beat = job_ff.data[1];
         default: beat = job_ff.data[2];
      endcase
   end

   always_comb begin
      job_in = job_ff;
      jv_in  = jv_ff;
      pos_in = pos_ff;
      ov_in  = ov_ff && !rsp_tready;
      ob_in  = ob_ff;
      oe_in  = oe_ff;
      if (adv) begin
         ov_in  = 1'b1;
         ob_in  = is_data ? beat : 8'd0;
         oe_in  = !is_data;
         pos_in = pos_ff + 1'b1;
         if (last_beat) begin
            jv_in  = 1'b0;
            pos_in = '0;
         end
      end
      if (pop) begin
         job_in = fifo_job;
         jv_in  = 1'b1;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      ob_ff  <= ob_in;
      oe_ff  <= oe_in;
      if (reset) begin
         jv_ff  <= 1'b0;
         pos_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         jv_ff  <= jv_in;
         pos_ff <= pos_in;
         ov_ff  <= ov_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = ob_ff;
   assign rsp_tlast  = oe_ff;

endmodule

[rtl/id3t_checker.sv]
// port-level checks for the transcoder, bound to the top level
module id3t_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // output register is empty right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp beat changed");

   // terminator always carries a zero byte
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == 8'd0)
      else $error("terminator with nonzero data");

   // zero units stop the string, so a zero byte is only ever the terminator
   a_zero_is_term: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == 8'd0 |-> rsp_tlast)
      else $error("zero data byte emitted");

endmodule

bind id3_text_to_utf8 id3t_checker u_id3t_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
